@@ rtl/fspu_pkg.sv @@
// shared types, constants and decode tables of the stack primitive unit
package fspu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int OP_WIDTH    = 6;
   localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
   localparam int SP_WIDTH    = ADDR_WIDTH + 1;

   typedef logic [DATA_WIDTH-1:0] cell_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_DROP  = 6'd0,  OP_SWAP  = 6'd1,  OP_DUP   = 6'd2,  OP_OVER  = 6'd3,
      OP_ROT   = 6'd4,  OP_NROT  = 6'd5,  OP_2DROP = 6'd6,  OP_2DUP  = 6'd7,
      OP_INC1  = 6'd8,  OP_DEC1  = 6'd9,  OP_INC4  = 6'd10, OP_DEC4  = 6'd11,
      OP_ADD   = 6'd12, OP_SUB   = 6'd13, OP_MUL   = 6'd14, OP_DIV   = 6'd15,
      OP_MOD   = 6'd16, OP_EQ    = 6'd17, OP_NE    = 6'd18, OP_LT    = 6'd19,
      OP_GT    = 6'd20, OP_LE    = 6'd21, OP_GE    = 6'd22, OP_ZEQ   = 6'd23,
      OP_ZNE   = 6'd24, OP_ZLT   = 6'd25, OP_ZGT   = 6'd26, OP_ZLE   = 6'd27,
      OP_ZGE   = 6'd28, OP_LAND  = 6'd29, OP_LOR   = 6'd30, OP_LNOT  = 6'd31,
      OP_BAND  = 6'd32, OP_BOR   = 6'd33, OP_BXOR  = 6'd34, OP_BNOT  = 6'd35,
      OP_PUSH  = 6'd36, OP_EMIT  = 6'd37
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_UNDER   = 2'd1,
      FAULT_OVER    = 2'd2,
      FAULT_DIVZERO = 2'd3
   } fault_type;

   typedef struct packed {
      logic start;
      logic want_rem;
   } div_req_type;

   // cells a primitive needs on the stack
   function automatic logic [1:0] need_count(input op_type op);
      logic [1:0] n;
      case (op)
         OP_PUSH: n = 2'd0;
         OP_DROP, OP_DUP, OP_INC1, OP_DEC1, OP_INC4, OP_DEC4, OP_ZEQ, OP_ZNE,
         OP_ZLT, OP_ZGT, OP_ZLE, OP_ZGE, OP_LNOT, OP_BNOT, OP_EMIT: n = 2'd1;
         OP_ROT, OP_NROT: n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   // free cells a primitive needs
   function automatic logic [1:0] room_count(input op_type op);
      logic [1:0] n;
      case (op)
         OP_DUP, OP_OVER, OP_PUSH: n = 2'd1;
         OP_2DUP: n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] to_out(input cell_type c);
      return OUT_WIDTH'($signed(c));
   endfunction

endpackage

@@ rtl/fspu_req_if.sv @@
// request channel of the stack primitive unit
interface fspu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [fspu_pkg::OP_WIDTH-1:0]        operation;
   logic signed [fspu_pkg::OUT_WIDTH-1:0] push_value;

   modport source(output valid, output operation, output push_value, input ready);
   modport sink(input valid, input operation, input push_value, output ready);
endinterface

@@ rtl/fspu_rsp_if.sv @@
// response channel of the stack primitive unit
interface fspu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fspu_pkg::OUT_WIDTH-1:0] top_value;
   logic signed [fspu_pkg::OUT_WIDTH-1:0] second_value;
   logic [fspu_pkg::SP_WIDTH-1:0]         stack_depth;
   logic                                  emit_valid;
   logic [7:0]                            emit_char;
   logic [1:0]                            fault;

   modport source(output valid, output top_value, output second_value, output stack_depth,
                  output emit_valid, output emit_char, output fault, input ready);
   modport sink(input valid, input top_value, input second_value, input stack_depth,
                input emit_valid, input emit_char, input fault, output ready);
endinterface

@@ rtl/fspu_ram.sv @@
// generic single-port ram with registered read
module fspu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/fspu_div.sv @@
// radix-2 restoring signed divider, truncating toward zero
module fspu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  fspu_pkg::div_req_type  div_req,
   input  fspu_pkg::cell_type     dividend,
   input  fspu_pkg::cell_type     divisor,
   output logic                   done,
   output fspu_pkg::cell_type     result
);
   localparam int W     = fspu_pkg::DATA_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     mb_ff, mb_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             rneg_ff, rneg_in;
   logic             qneg_ff, qneg_in;
   logic             want_rem_ff, want_rem_in;
   logic [W:0]       trial;
   logic             na, nb;

   always_comb begin
      na          = dividend[W-1];
      nb          = divisor[W-1];
      trial       = {rem_ff, quo_ff[W-1]} - {1'b0, mb_ff};
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      mb_in       = mb_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      rneg_in     = rneg_ff;
      qneg_in     = qneg_ff;
      want_rem_in = want_rem_ff;
      if (div_req.start) begin
         rem_in      = '0;
         quo_in      = na ? (~dividend + 1'b1) : dividend;
         mb_in       = nb ? (~divisor + 1'b1) : divisor;
         cnt_in      = CNT_W'(W);
         busy_in     = 1'b1;
         rneg_in     = na;
         qneg_in     = na ^ nb;
         want_rem_in = div_req.want_rem;
      end else if (busy_ff) begin
         rem_in = trial[W] ? {rem_ff[W-2:0], quo_ff[W-1]} : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mb_ff       <= mb_in;
      cnt_ff      <= cnt_in;
      rneg_ff     <= rneg_in;
      qneg_ff     <= qneg_in;
      want_rem_ff <= want_rem_in;
   end

   assign done   = done_ff;
   assign result = want_rem_ff ? (rneg_ff ? (~rem_ff + 1'b1) : rem_ff)
                               : (qneg_ff ? (~quo_ff + 1'b1) : quo_ff);
endmodule

@@ rtl/forth_stack_primitive_unit.sv @@
// Forth data-stack primitive unit: top three cells in registers, the rest in a
// single-port ram with registered read. An item that keeps the depth or pushes
// one cell goes from idle to the done state; one that pops one cell adds one ram
// read to refill the third cell, 2dup adds a second spill write, 2drop adds two
// refill reads. Divide and modulo run through a bit-serial divider, one quotient
// bit a cycle, then pop like the other binary items. A new request is taken
// while the previous response still waits to be accepted.
module forth_stack_primitive_unit (
   input logic         clock,
   input logic         reset,
   fspu_req_if.sink    req_if,
   fspu_rsp_if.source  rsp_if
);
   localparam int W  = fspu_pkg::DATA_WIDTH;
   localparam int AW = fspu_pkg::ADDR_WIDTH;
   localparam int SW = fspu_pkg::SP_WIDTH;
   localparam int OW = fspu_pkg::OUT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_RD_S, ST_RD_U, ST_WR2, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   fspu_pkg::cell_type   t_ff, t_in, s_ff, s_in, u_ff, u_in, spill_ff, spill_in;
   logic [SW-1:0]        sp_ff, sp_in;
   logic                 ev_ff, ev_in;
   logic [7:0]           ec_ff, ec_in;
   fspu_pkg::fault_type  fault_ff, fault_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]        top_ff, top_in, second_ff, second_in;
   logic [SW-1:0]        depth_ff, depth_in;
   logic                 oev_ff, oev_in;
   logic [7:0]           oec_ff, oec_in;
   logic [1:0]           ofault_ff, ofault_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_addr;
   fspu_pkg::cell_type   mem_wdata, mem_rdata;
   fspu_pkg::div_req_type div_req;
   logic                 div_done;
   fspu_pkg::cell_type   div_result;

   fspu_pkg::op_type     op;
   fspu_pkg::fault_type  fault_c;
   fspu_pkg::cell_type   bin_r, pv_cell;
   logic [AW-1:0]        sp_lo;

   function automatic fspu_pkg::cell_type to_cell(input logic b);
      return {{(W-1){1'b0}}, b};
   endfunction

   fspu_ram #(.WIDTH(W), .DEPTH(fspu_pkg::STACK_DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   fspu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (s_ff),
      .divisor  (t_ff),
      .done     (div_done),
      .result   (div_result)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign op           = fspu_pkg::op_type'(req_if.operation);
   assign pv_cell      = W'($signed(req_if.push_value));
   assign sp_lo        = sp_ff[AW-1:0];

   // fault check
   always_comb begin
      fault_c = fspu_pkg::FAULT_NONE;
      if (op <= fspu_pkg::OP_EMIT) begin
         if (sp_ff < SW'(fspu_pkg::need_count(op))) begin
            fault_c = fspu_pkg::FAULT_UNDER;
         end else if (({1'b0, sp_ff} + (SW+1)'(fspu_pkg::room_count(op)))
                      > (SW+1)'(fspu_pkg::STACK_DEPTH)) begin
            fault_c = fspu_pkg::FAULT_OVER;
         end else if ((op == fspu_pkg::OP_DIV || op == fspu_pkg::OP_MOD) && t_ff == '0) begin
            fault_c = fspu_pkg::FAULT_DIVZERO;
         end
      end
   end

   // binary results
   always_comb begin
      case (op)
         fspu_pkg::OP_ADD:  bin_r = s_ff + t_ff;
         fspu_pkg::OP_SUB:  bin_r = s_ff - t_ff;
         fspu_pkg::OP_MUL:  bin_r = W'(s_ff * t_ff);
         fspu_pkg::OP_EQ:   bin_r = to_cell(s_ff == t_ff);
         fspu_pkg::OP_NE:   bin_r = to_cell(s_ff != t_ff);
         fspu_pkg::OP_LT:   bin_r = to_cell($signed(s_ff) < $signed(t_ff));
         fspu_pkg::OP_GT:   bin_r = to_cell($signed(s_ff) > $signed(t_ff));
         fspu_pkg::OP_LE:   bin_r = to_cell($signed(s_ff) <= $signed(t_ff));
         fspu_pkg::OP_GE:   bin_r = to_cell($signed(s_ff) >= $signed(t_ff));
         fspu_pkg::OP_LAND: bin_r = to_cell(s_ff != '0 && t_ff != '0);
         fspu_pkg::OP_LOR:  bin_r = to_cell(s_ff != '0 || t_ff != '0);
         fspu_pkg::OP_BAND: bin_r = s_ff & t_ff;
         fspu_pkg::OP_BOR:  bin_r = s_ff | t_ff;
         default:           bin_r = s_ff ^ t_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      u_in         = u_ff;
      spill_in     = spill_ff;
      sp_in        = sp_ff;
      ev_in        = ev_ff;
      ec_in        = ec_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      top_in       = top_ff;
      second_in    = second_ff;
      depth_in     = depth_ff;
      oev_in       = oev_ff;
      oec_in       = oec_ff;
      ofault_in    = ofault_ff;
      mem_we       = 1'b0;
      mem_addr     = sp_lo - AW'(3);
      mem_wdata    = u_ff;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               fault_in = fault_c;
               ev_in    = 1'b0;
               ec_in    = '0;
               state_in = ST_DONE;
               if (fault_c == fspu_pkg::FAULT_NONE) begin
                  case (op)
                     fspu_pkg::OP_DROP, fspu_pkg::OP_EMIT: begin
                        t_in     = s_ff;
                        s_in     = u_ff;
                        sp_in    = sp_ff - 1'b1;
                        mem_addr = sp_lo - AW'(4);
                        state_in = ST_RD_U;
                        if (op == fspu_pkg::OP_EMIT) begin
                           ev_in = 1'b1;
                           ec_in = t_ff[7:0];
                        end
                     end
                     fspu_pkg::OP_SWAP: begin
                        t_in = s_ff;
                        s_in = t_ff;
                     end
                     fspu_pkg::OP_ROT: begin
                        t_in = u_ff;
                        s_in = t_ff;
                        u_in = s_ff;
                     end
                     fspu_pkg::OP_NROT: begin
                        t_in = s_ff;
                        s_in = u_ff;
                        u_in = t_ff;
                     end
                     fspu_pkg::OP_DUP, fspu_pkg::OP_OVER, fspu_pkg::OP_PUSH: begin
                        mem_we = 1'b1;
                        t_in   = (op == fspu_pkg::OP_DUP) ? t_ff :
                                 (op == fspu_pkg::OP_OVER) ? s_ff : pv_cell;
                        s_in   = t_ff;
                        u_in   = s_ff;
                        sp_in  = sp_ff + 1'b1;
                     end
                     fspu_pkg::OP_2DUP: begin
                        mem_we   = 1'b1;
                        u_in     = t_ff;
                        spill_in = s_ff;
                        sp_in    = sp_ff + SW'(2);
                        state_in = ST_WR2;
                     end
                     fspu_pkg::OP_2DROP: begin
                        t_in     = u_ff;
                        sp_in    = sp_ff - SW'(2);
                        mem_addr = sp_lo - AW'(4);
                        state_in = ST_RD_S;
                     end
                     fspu_pkg::OP_INC1: t_in = t_ff + W'(1);
                     fspu_pkg::OP_DEC1: t_in = t_ff - W'(1);
                     fspu_pkg::OP_INC4: t_in = t_ff + W'(4);
                     fspu_pkg::OP_DEC4: t_in = t_ff - W'(4);
                     fspu_pkg::OP_ZEQ, fspu_pkg::OP_LNOT: t_in = to_cell(t_ff == '0);
                     fspu_pkg::OP_ZNE:  t_in = to_cell(t_ff != '0);
                     fspu_pkg::OP_ZLT:  t_in = to_cell(t_ff[W-1]);
                     fspu_pkg::OP_ZGT:  t_in = to_cell($signed(t_ff) > 0);
                     fspu_pkg::OP_ZLE:  t_in = to_cell(!($signed(t_ff) > 0));
                     fspu_pkg::OP_ZGE:  t_in = to_cell(!t_ff[W-1]);
                     fspu_pkg::OP_BNOT: t_in = ~t_ff;
                     fspu_pkg::OP_DIV, fspu_pkg::OP_MOD: begin
                        div_req.start    = 1'b1;
                        div_req.want_rem = (op == fspu_pkg::OP_MOD);
                        state_in         = ST_DIV;
                     end
                     fspu_pkg::OP_ADD, fspu_pkg::OP_SUB, fspu_pkg::OP_MUL, fspu_pkg::OP_EQ,
                     fspu_pkg::OP_NE, fspu_pkg::OP_LT, fspu_pkg::OP_GT, fspu_pkg::OP_LE,
                     fspu_pkg::OP_GE, fspu_pkg::OP_LAND, fspu_pkg::OP_LOR, fspu_pkg::OP_BAND,
                     fspu_pkg::OP_BOR, fspu_pkg::OP_BXOR: begin
                        t_in     = bin_r;
                        s_in     = u_ff;
                        sp_in    = sp_ff - 1'b1;
                        mem_addr = sp_lo - AW'(4);
                        state_in = ST_RD_U;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_in     = div_result;
               s_in     = u_ff;
               sp_in    = sp_ff - 1'b1;
               mem_addr = sp_lo - AW'(4);
               state_in = ST_RD_U;
            end
         end
         ST_RD_S: begin
            s_in     = mem_rdata;
            mem_addr = sp_lo - AW'(3);
            state_in = ST_RD_U;
         end
         ST_RD_U: begin
            u_in     = mem_rdata;
            state_in = ST_DONE;
         end
         ST_WR2: begin
            mem_we    = 1'b1;
            mem_addr  = sp_lo - AW'(4);
            mem_wdata = spill_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               top_in       = (sp_ff >= SW'(1)) ? fspu_pkg::to_out(t_ff) : '0;
               second_in    = (sp_ff >= SW'(2)) ? fspu_pkg::to_out(s_ff) : '0;
               depth_in     = sp_ff;
               oev_in       = ev_ff;
               oec_in       = ec_ff;
               ofault_in    = fault_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff      <= t_in;
      s_ff      <= s_in;
      u_ff      <= u_in;
      spill_ff  <= spill_in;
      ev_ff     <= ev_in;
      ec_ff     <= ec_in;
      fault_ff  <= fault_in;
      top_ff    <= top_in;
      second_ff <= second_in;
      depth_ff  <= depth_in;
      oev_ff    <= oev_in;
      oec_ff    <= oec_in;
      ofault_ff <= ofault_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.top_value    = top_ff;
   assign rsp_if.second_value = second_ff;
   assign rsp_if.stack_depth  = depth_ff;
   assign rsp_if.emit_valid   = oev_ff;
   assign rsp_if.emit_char    = oec_ff;
   assign rsp_if.fault        = ofault_ff;
endmodule
